>>> hw/rtl/rc4_pkg.sv
package rc4_pkg;

   localparam int BYTE_W     = 8;
   localparam int SBOX_DEPTH = 256;
   localparam int KEY_DEPTH  = 256;
   localparam int KEY_MAX    = 256;
   localparam int CNT_W      = 9;
   localparam int STEP_W     = 4;

   localparam logic [CNT_W-1:0]  KEY_MAX_CNT = CNT_W'(KEY_MAX);
   localparam logic [BYTE_W-1:0] BYTE_MAX    = 8'hFF;

   typedef struct packed {
      logic              kind;
      logic [BYTE_W-1:0] value;
      logic              last;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              error;
      logic              end_of_run;
   } rsp_type;

   // sequencer steps
   localparam logic [STEP_W-1:0] STEP_IDLE = 4'd0;
   localparam logic [STEP_W-1:0] STEP_ERR  = 4'd1;
   localparam logic [STEP_W-1:0] STEP_D0   = 4'd2;
   localparam logic [STEP_W-1:0] STEP_D1   = 4'd3;
   localparam logic [STEP_W-1:0] STEP_D2   = 4'd4;
   localparam logic [STEP_W-1:0] STEP_D3   = 4'd5;
   localparam logic [STEP_W-1:0] STEP_K0   = 4'd6;
   localparam logic [STEP_W-1:0] STEP_K1   = 4'd7;
   localparam logic [STEP_W-1:0] STEP_K2   = 4'd8;
   localparam logic [STEP_W-1:0] STEP_K3   = 4'd9;
   localparam logic [STEP_W-1:0] STEP_K4   = 4'd10;
   localparam logic [STEP_W-1:0] STEP_K5   = 4'd11;

   // S-box read address select
   localparam logic [1:0] RA_I_INC = 2'd0;
   localparam logic [1:0] RA_I     = 2'd1;
   localparam logic [1:0] RA_JNEXT = 2'd2;
   localparam logic [1:0] RA_K     = 2'd3;

   localparam logic [1:0] I_HOLD  = 2'd0;
   localparam logic [1:0] I_INC   = 2'd1;
   localparam logic [1:0] I_CLEAR = 2'd2;

   localparam logic [1:0] J_HOLD  = 2'd0;
   localparam logic [1:0] J_NEXT  = 2'd1;
   localparam logic [1:0] J_CLEAR = 2'd2;

   localparam logic [1:0] WR_NONE = 2'd0;
   localparam logic [1:0] WR_I_SJ = 2'd1;
   localparam logic [1:0] WR_J_SI = 2'd2;

   localparam logic [1:0] KP_HOLD  = 2'd0;
   localparam logic [1:0] KP_CLEAR = 2'd1;
   localparam logic [1:0] KP_STEP  = 2'd2;

   localparam logic [1:0] EM_NONE = 2'd0;
   localparam logic [1:0] EM_DATA = 2'd1;
   localparam logic [1:0] EM_ERR  = 2'd2;

   localparam logic [1:0] SEQ_NEXT     = 2'd0;
   localparam logic [1:0] SEQ_IDLE     = 2'd1;
   localparam logic [1:0] SEQ_LOOP     = 2'd2;
   localparam logic [1:0] SEQ_DISPATCH = 2'd3;

   typedef struct packed {
      logic [1:0]        rd_addr;
      logic              rd_en;
      logic              cap_si;
      logic              cap_sj;
      logic [1:0]        i_op;
      logic [1:0]        j_op;
      logic              add_key;
      logic [1:0]        wr_op;
      logic [1:0]        kp_op;
      logic              vclr;
      logic [1:0]        emit;
      logic              set_keyed;
      logic [1:0]        seq;
      logic [STEP_W-1:0] target;
   } ctrl_type;

   // microcode store
   function automatic ctrl_type ucode(input logic [STEP_W-1:0] step);
      ctrl_type c;
      c = '0;
      unique case (step)
         STEP_IDLE: begin
            c.seq = SEQ_DISPATCH;
         end
         STEP_ERR: begin
            c.emit = EM_ERR;
            c.seq  = SEQ_IDLE;
         end
         STEP_D0: begin
            c.rd_en   = 1'b1;
            c.rd_addr = RA_I_INC;
            c.i_op    = I_INC;
         end
         STEP_D1: begin
            c.rd_en   = 1'b1;
            c.rd_addr = RA_JNEXT;
            c.cap_si  = 1'b1;
            c.j_op    = J_NEXT;
         end
         STEP_D2: begin
            c.rd_en   = 1'b1;
            c.rd_addr = RA_K;
            c.cap_sj  = 1'b1;
            c.wr_op   = WR_I_SJ;
         end
         STEP_D3: begin
            c.wr_op = WR_J_SI;
            c.emit  = EM_DATA;
            c.seq   = SEQ_IDLE;
         end
         STEP_K0: begin
            c.vclr  = 1'b1;
            c.i_op  = I_CLEAR;
            c.j_op  = J_CLEAR;
            c.kp_op = KP_CLEAR;
         end
         STEP_K1: begin
            c.rd_en   = 1'b1;
            c.rd_addr = RA_I;
         end
         STEP_K2: begin
            c.rd_en   = 1'b1;
            c.rd_addr = RA_JNEXT;
            c.cap_si  = 1'b1;
            c.j_op    = J_NEXT;
            c.add_key = 1'b1;
         end
         STEP_K3: begin
            c.cap_sj = 1'b1;
            c.wr_op  = WR_I_SJ;
         end
         STEP_K4: begin
            c.wr_op  = WR_J_SI;
            c.i_op   = I_INC;
            c.kp_op  = KP_STEP;
            c.seq    = SEQ_LOOP;
            c.target = STEP_K1;
         end
         STEP_K5: begin
            c.j_op      = J_CLEAR;
            c.set_keyed = 1'b1;
            c.seq       = SEQ_IDLE;
         end
         default: begin
            c.seq = SEQ_IDLE;
         end
      endcase
      return c;
   endfunction

endpackage

>>> hw/rtl/rc4_ram.sv
module rc4_ram #(
   parameter int  WIDTH  = 8,
   parameter int  DEPTH  = 256,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/rc4_stream_cipher.sv
// Channel  Handshake            Payload              Moves
// req      req_valid/req_stall  rc4_pkg::req_type    key byte or data byte in
// rsp      rsp_valid/rsp_stall  rc4_pkg::rsp_type    one result per data byte
//
// A key byte is taken in IDLE. A keyed data byte runs steps D0 to D3, an unkeyed one
// runs ERR. The last key byte adds the key schedule (unless the key overran KEY_MAX):
// K0, then K1 to K4 per S-box entry, then K5, bound by the single read port of the S-box memory.
// Reset sets the S-box to identity at once through per-entry valid bits.
// A result waits in the output register under rsp_stall; the next item is
// taken meanwhile and only the step that emits a result waits for the slot.
module rc4_stream_cipher (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rc4_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rc4_pkg::rsp_type rsp_data
);

   localparam int BW = rc4_pkg::BYTE_W;
   localparam int CW = rc4_pkg::CNT_W;
   localparam int SW = rc4_pkg::STEP_W;

   logic [SW-1:0]              pc_ff, pc_in;
   logic [BW-1:0]              i_ff, i_in;
   logic [BW-1:0]              j_ff, j_in;
   logic [BW-1:0]              kp_ff, kp_in;
   logic [CW-1:0]              len_ff, len_in;
   logic [CW-1:0]              key_count_ff, key_count_in;
   logic                       ovf_ff, ovf_in;
   logic                       keyed_ff, keyed_in;
   logic [BW-1:0]              si_ff, si_in;
   logic [BW-1:0]              sj_ff, sj_in;
   logic [BW-1:0]              val_ff, val_in;
   logic                       last_ff, last_in;
   logic                       keq_i_ff, keq_i_in;
   logic                       keq_j_ff, keq_j_in;
   logic [rc4_pkg::SBOX_DEPTH-1:0] sv_ff, sv_in;
   logic                       sv_q_ff, sv_q_in;
   logic [BW-1:0]              sa_q_ff, sa_q_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rc4_pkg::rsp_type           rsp_data_ff, rsp_data_in;

   rc4_pkg::ctrl_type ctrl;
   logic          accept, key_acc, key_room, key_wr, out_free, go;
   logic [CW-1:0] cnt_new;
   logic          ovf_new;
   logic [BW-1:0] s_q, key_q, sbox_rd, j_next, k_addr, ks, key_add;
   logic [BW-1:0] s_rd_addr, s_wr_addr, s_wr_data;
   logic          s_wr_en;
   logic [CW-1:0] kp_inc;

   assign ctrl      = rc4_pkg::ucode(pc_ff);
   assign req_stall = (pc_ff != rc4_pkg::STEP_IDLE);
   assign accept    = req_valid && !req_stall;
   assign key_acc   = accept && !req_data.kind;
   assign key_room  = key_count_ff < rc4_pkg::KEY_MAX_CNT;
   assign key_wr    = key_acc && key_room;
   assign cnt_new   = key_room ? CW'(key_count_ff + 1'b1) : key_count_ff;
   assign ovf_new   = ovf_ff || !key_room;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign go        = (ctrl.emit == rc4_pkg::EM_NONE) || out_free;

   assign sbox_rd = sv_q_ff ? s_q : sa_q_ff;
   assign key_add = ctrl.add_key ? key_q : '0;
   assign j_next  = BW'(j_ff + sbox_rd + key_add);
   assign k_addr  = BW'(si_ff + sbox_rd);
   assign kp_inc  = {1'b0, kp_ff} + CW'(1);
   assign ks      = keq_j_ff ? si_ff : (keq_i_ff ? sj_ff : sbox_rd);

   always_comb begin
      unique case (ctrl.rd_addr)
         rc4_pkg::RA_I_INC: s_rd_addr = BW'(i_ff + 1'b1);
         rc4_pkg::RA_I:     s_rd_addr = i_ff;
         rc4_pkg::RA_JNEXT: s_rd_addr = j_next;
         rc4_pkg::RA_K:     s_rd_addr = k_addr;
         default:           s_rd_addr = i_ff;
      endcase
   end

   always_comb begin
      s_wr_en   = 1'b0;
      s_wr_addr = i_ff;
      s_wr_data = sbox_rd;
      unique case (ctrl.wr_op)
         rc4_pkg::WR_NONE: s_wr_en = 1'b0;
         rc4_pkg::WR_I_SJ: begin
            s_wr_en   = 1'b1;
            s_wr_addr = i_ff;
            s_wr_data = sbox_rd;
         end
         rc4_pkg::WR_J_SI: begin
            s_wr_en   = 1'b1;
            s_wr_addr = j_ff;
            s_wr_data = si_ff;
         end
         default: s_wr_en = 1'b0;
      endcase
   end

   rc4_ram #(.WIDTH(rc4_pkg::BYTE_W), .DEPTH(rc4_pkg::SBOX_DEPTH)) u_sbox (
      .clock   (clock),
      .wr_en   (s_wr_en),
      .wr_addr (s_wr_addr),
      .wr_data (s_wr_data),
      .rd_en   (ctrl.rd_en),
      .rd_addr (s_rd_addr),
      .rd_data (s_q)
   );

   rc4_ram #(.WIDTH(rc4_pkg::BYTE_W), .DEPTH(rc4_pkg::KEY_DEPTH)) u_key (
      .clock   (clock),
      .wr_en   (key_wr),
      .wr_addr (key_count_ff[BW-1:0]),
      .wr_data (req_data.value),
      .rd_en   (1'b1),
      .rd_addr (kp_ff),
      .rd_data (key_q)
   );

   always_comb begin
      pc_in        = pc_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      kp_in        = kp_ff;
      len_in       = len_ff;
      key_count_in = key_count_ff;
      ovf_in       = ovf_ff;
      keyed_in     = keyed_ff;
      si_in        = ctrl.cap_si ? sbox_rd : si_ff;
      sj_in        = ctrl.cap_sj ? sbox_rd : sj_ff;
      val_in       = val_ff;
      last_in      = last_ff;
      keq_i_in     = keq_i_ff;
      keq_j_in     = keq_j_ff;
      sv_in        = sv_ff;
      sv_q_in      = sv_q_ff;
      sa_q_in      = sa_q_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      unique case (ctrl.i_op)
         rc4_pkg::I_HOLD:  i_in = i_ff;
         rc4_pkg::I_INC:   i_in = BW'(i_ff + 1'b1);
         rc4_pkg::I_CLEAR: i_in = '0;
         default:          i_in = i_ff;
      endcase

      unique case (ctrl.j_op)
         rc4_pkg::J_HOLD:  j_in = j_ff;
         rc4_pkg::J_NEXT:  j_in = j_next;
         rc4_pkg::J_CLEAR: j_in = '0;
         default:          j_in = j_ff;
      endcase

      unique case (ctrl.kp_op)
         rc4_pkg::KP_HOLD:  kp_in = kp_ff;
         rc4_pkg::KP_CLEAR: kp_in = '0;
         rc4_pkg::KP_STEP:  kp_in = (kp_inc == len_ff) ? '0 : kp_inc[BW-1:0];
         default:           kp_in = kp_ff;
      endcase

      if (ctrl.rd_en) begin
         sv_q_in = sv_ff[s_rd_addr];
         sa_q_in = s_rd_addr;
      end
      if (ctrl.rd_en && ctrl.rd_addr == rc4_pkg::RA_K) begin
         keq_i_in = (k_addr == i_ff);
         keq_j_in = (k_addr == j_ff);
      end

      if (ctrl.vclr) begin
         sv_in = '0;
      end
      if (s_wr_en) begin
         sv_in[s_wr_addr] = 1'b1;
      end

      if (ctrl.set_keyed) begin
         keyed_in = 1'b1;
      end

      if (key_acc) begin
         keyed_in = 1'b0;
         if (req_data.last) begin
            key_count_in = '0;
            ovf_in       = 1'b0;
            len_in       = cnt_new;
         end else begin
            key_count_in = cnt_new;
            ovf_in       = ovf_new;
         end
      end
      if (accept && req_data.kind) begin
         val_in  = req_data.value;
         last_in = req_data.last;
      end

      if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (ctrl.emit != rc4_pkg::EM_NONE && out_free) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.end_of_run = last_ff;
         if (ctrl.emit == rc4_pkg::EM_ERR) begin
            rsp_data_in.out_byte = '0;
            rsp_data_in.error    = 1'b1;
         end else begin
            rsp_data_in.out_byte = val_ff ^ ks;
            rsp_data_in.error    = 1'b0;
         end
      end

      if (go) begin
         unique case (ctrl.seq)
            rc4_pkg::SEQ_NEXT: pc_in = SW'(pc_ff + 1'b1);
            rc4_pkg::SEQ_IDLE: pc_in = rc4_pkg::STEP_IDLE;
            rc4_pkg::SEQ_LOOP: begin
               pc_in = (i_ff != rc4_pkg::BYTE_MAX) ? ctrl.target : SW'(pc_ff + 1'b1);
            end
            rc4_pkg::SEQ_DISPATCH: begin
               priority if (!accept) begin
                  pc_in = rc4_pkg::STEP_IDLE;
               end else if (req_data.kind) begin
                  pc_in = keyed_ff ? rc4_pkg::STEP_D0 : rc4_pkg::STEP_ERR;
               end else if (req_data.last && !ovf_new) begin
                  pc_in = rc4_pkg::STEP_K0;
               end else begin
                  pc_in = rc4_pkg::STEP_IDLE;
               end
            end
            default: pc_in = rc4_pkg::STEP_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= rc4_pkg::STEP_IDLE;
         i_ff         <= '0;
         j_ff         <= '0;
         kp_ff        <= '0;
         key_count_ff <= '0;
         ovf_ff       <= 1'b0;
         keyed_ff     <= 1'b0;
         sv_ff        <= '0;
         sv_q_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         kp_ff        <= kp_in;
         key_count_ff <= key_count_in;
         ovf_ff       <= ovf_in;
         keyed_ff     <= keyed_in;
         sv_ff        <= sv_in;
         sv_q_ff      <= sv_q_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      len_ff      <= len_in;
      si_ff       <= si_in;
      sj_ff       <= sj_in;
      val_ff      <= val_in;
      last_ff     <= last_in;
      keq_i_ff    <= keq_i_in;
      keq_j_ff    <= keq_j_in;
      sa_q_ff     <= sa_q_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> hw/rtl/rc4_checker.sv
module rc4_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input rc4_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input rc4_pkg::rsp_type rsp_data
);

   // held result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp payload changed while stalled");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.error |-> rsp_data.out_byte == 8'd0)
      else $error("error result with nonzero byte");

   a_reset_idle: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result right after reset");

   a_key_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_data.kind && !rsp_valid |=> !rsp_valid)
      else $error("key byte produced a result");

   a_data_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.kind |=> req_stall)
      else $error("data transfer not followed by busy");

endmodule

bind rc4_stream_cipher rc4_checker u_rc4_checker (.*);

>>> tb/rc4_stream_cipher_tb_pkg.sv
`timescale 1ns / 100ps
package rc4_stream_cipher_tb_pkg;

   localparam logic KIND_KEY  = 1'b0;
   localparam logic KIND_DATA = 1'b1;

endpackage

>>> tb/rc4_keystream_check.sv
`timescale 1ns / 100ps
module rc4_keystream_check
   import rc4_pkg::*;
   import rc4_stream_cipher_tb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending,
   output int      result_count,
   output int      unkeyed_count
);

   logic [BYTE_W-1:0] perm [SBOX_DEPTH];
   logic [BYTE_W-1:0] key_bytes [KEY_DEPTH];
   logic [CNT_W-1:0]  key_len;
   logic [BYTE_W-1:0] idx_i;
   logic [BYTE_W-1:0] idx_j;
   logic              keyed;
   logic              key_overflow;
   rsp_type           cipher_out_q [$];

   function automatic void perm_identity();
      for (int n = 0; n < SBOX_DEPTH; n++) perm[n] = BYTE_W'(n);
   endfunction

   // advances the cipher model by one byte; returns 1 when a result is due
   function automatic bit cipher_step(input req_type item, output rsp_type res);
      logic [BYTE_W-1:0] j;
      logic [BYTE_W-1:0] t;
      res = '0;
      if (item.kind == KIND_KEY) begin
         keyed = 1'b0;
         if (key_len < KEY_MAX_CNT) begin
            key_bytes[key_len[BYTE_W-1:0]] = item.value;
            key_len = key_len + 1'b1;
         end else begin
            key_overflow = 1'b1;
         end
         if (item.last) begin
            if (!key_overflow && key_len != '0) begin
               perm_identity();
               j = '0;
               for (int n = 0; n < SBOX_DEPTH; n++) begin
                  j = j + perm[n] + key_bytes[n % key_len];
                  t = perm[n];
                  perm[n] = perm[j];
                  perm[j] = t;
               end
               idx_i = '0;
               idx_j = '0;
               keyed = 1'b1;
            end
            key_len = '0;
            key_overflow = 1'b0;
         end
         return 1'b0;
      end
      res.end_of_run = item.last;
      if (!keyed) begin
         res.error = 1'b1;
         return 1'b1;
      end
      idx_i = idx_i + 1'b1;
      idx_j = idx_j + perm[idx_i];
      t = perm[idx_i];
      perm[idx_i] = perm[idx_j];
      perm[idx_j] = t;
      res.out_byte = item.value ^ perm[BYTE_W'(perm[idx_i] + perm[idx_j])];
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      int      errs;
      errs = 0;
      if (reset) begin
         perm_identity();
         key_len = '0;
         idx_i = '0;
         idx_j = '0;
         keyed = 1'b0;
         key_overflow = 1'b0;
         cipher_out_q.delete();
         fail_count <= 0;
         result_count <= 0;
         unkeyed_count <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            if (cipher_step(req_data, want)) cipher_out_q.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            result_count <= result_count + 1;
            if (rsp_data.error) unkeyed_count <= unkeyed_count + 1;
            if (cipher_out_q.size() == 0) begin
               $display("%0t: result with none expected, got %p", $time, rsp_data);
               errs++;
            end else begin
               want = cipher_out_q.pop_front();
               if (rsp_data.out_byte !== want.out_byte) begin
                  $display("%0t: out_byte expected %02h, got %02h",
                           $time, want.out_byte, rsp_data.out_byte);
                  errs++;
               end
               if (rsp_data.error !== want.error) begin
                  $display("%0t: error expected %b, got %b",
                           $time, want.error, rsp_data.error);
                  errs++;
               end
               if (rsp_data.end_of_run !== want.end_of_run) begin
                  $display("%0t: end_of_run expected %b, got %b",
                           $time, want.end_of_run, rsp_data.end_of_run);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
      end
      pending <= cipher_out_q.size();
   end

endmodule

>>> tb/rc4_stream_cipher_tb.sv
`timescale 1ns / 100ps
module rc4_stream_cipher_tb;
   import rc4_pkg::*;
   import rc4_stream_cipher_tb_pkg::*;

   localparam int ITEMS       = 1900;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int TAIL_CYCLES = 1100;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data  = '0;
   logic    rsp_stall = 1'b0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;

   int fail_count;
   int pending;
   int result_count;
   int unkeyed_count;
   int cycle_count   = 0;
   int items_sent    = 0;
   int key_loads     = 0;
   int full_keys     = 0;
   int overflow_keys = 0;
   bit calm          = 1'b0;

   always #5 clock = ~clock;

   rc4_stream_cipher u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   rc4_keystream_check u_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending       (pending),
      .result_count  (result_count),
      .unkeyed_count (unkeyed_count)
   );

   always @(negedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 9);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // called and returns at a falling edge; valid stays high into the next call
   task automatic send_item(input logic kind, input logic [BYTE_W-1:0] value,
                            input logic last);
      req_type item;
      item = {kind, value, last};
      while (!calm && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic load_key(input int len, input bit close);
      for (int k = 1; k <= len; k++)
         send_item(KIND_KEY, BYTE_W'($urandom_range(255)), close && k == len);
      if (close) key_loads++;
   endtask

   task automatic send_data(input int len);
      for (int k = 1; k <= len; k++)
         send_item(KIND_DATA, BYTE_W'($urandom_range(255)),
                   k == len || $urandom_range(7) == 0);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
   endtask

   initial begin
      int r;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // data before any key
      send_item(KIND_DATA, 8'h00, 1'b0);
      send_item(KIND_DATA, 8'hFF, 1'b1);
      // single-byte key
      send_item(KIND_KEY, 8'hFF, 1'b1);
      send_item(KIND_DATA, 8'h00, 1'b0);
      send_item(KIND_DATA, 8'hFF, 1'b0);
      send_item(KIND_DATA, 8'h5A, 1'b1);
      // new key while keyed, data in the middle of the load
      send_item(KIND_KEY, 8'h00, 1'b0);
      send_item(KIND_DATA, 8'h33, 1'b1);
      send_item(KIND_KEY, 8'h80, 1'b0);
      send_item(KIND_KEY, 8'h01, 1'b1);
      send_item(KIND_DATA, 8'hFF, 1'b0);
      send_item(KIND_DATA, 8'h00, 1'b0);
      send_item(KIND_DATA, 8'h80, 1'b0);
      send_item(KIND_DATA, 8'h01, 1'b1);
      send_item(KIND_DATA, 8'hA5, 1'b0);
      send_item(KIND_DATA, 8'h7E, 1'b1);
      drain();

      for (int s = 0; items_sent < ITEMS; s++) begin
         calm <= (s >= 24 && s < 36);
         r = $urandom_range(99);
         if (s == 0 || r < 2) begin
            load_key(KEY_MAX, 1'b1);
            full_keys++;
         end else if (s == 1 || r < 4) begin
            load_key(KEY_MAX + 1 + $urandom_range(3), 1'b1);
            overflow_keys++;
         end else if (r < 10) begin
            // unterminated load: data comes back flagged, next load continues it
            load_key(1 + $urandom_range(3), 1'b0);
         end else begin
            load_key(1 + $urandom_range(15), 1'b1);
         end
         send_data(1 + $urandom_range(39));
         if (s % 16 == 15) drain();
      end

      drain();
      repeat (TAIL_CYCLES) @(negedge clock);
      $display("Drove %0d bytes over %0d key loads (%0d full length, %0d overrun).",
               items_sent, key_loads, full_keys, overflow_keys);
      $display("Checked %0d cipher results, %0d of them flagged unkeyed.",
               result_count, unkeyed_count);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
